// ===== rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Types, widths and constants shared by the PID rate controller files.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int GAIN_W    = 16;
    localparam int DATA_W    = 16;
    localparam int TIME_W    = 32;
    localparam int DRIVE_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam int ERR_W  = DATA_W + 1;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int INC_W  = 64;
    localparam int ACC_W  = 48;
    localparam int P_W    = GAIN_W + ERR_W;
    localparam int QUO_W  = 17;
    localparam int D_W    = QUO_W + 1;
    localparam int NUM_W  = 43;
    localparam int MAG_W  = NUM_W - 1;
    localparam int LIM_W  = TIME_W + QUO_W;
    localparam int SUM_W  = 50;
    localparam int FRAC_W = 8;
    localparam int SHR_W  = SUM_W - FRAC_W;
    localparam int CNT_W  = $clog2(QUO_W);

    localparam int D_LIMIT_Q = 128000;
    localparam int MS_PER_S  = 1000;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_KE,
        S_MUL_INC,
        S_MUL_KD,
        S_MUL_NUM,
        S_MUL_LIM,
        S_CMP,
        S_DIV,
        S_SUM,
        S_OUT
    } t_state;

endpackage

// ===== rtl/prc_if.sv =====
// ----------------------------------------------------------------------------
// prc_if
// Valid/ready channels of the PID rate controller: step, result and config.
// ----------------------------------------------------------------------------
interface prc_step_if import prc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     clear_integral;
    logic signed [DATA_W-1:0] measurement;
    logic signed [DATA_W-1:0] reference;
    logic [TIME_W-1:0]        now_ms;

    modport source (output valid, clear_integral, measurement, reference, now_ms,
                    input ready);
    modport sink   (input valid, clear_integral, measurement, reference, now_ms,
                    output ready);
endinterface

interface prc_result_if import prc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic                      derivative_zeroed;
    logic                      integral_saturated;

    modport source (output valid, drive, derivative_zeroed, integral_saturated,
                    input ready);
    modport sink   (input valid, drive, derivative_zeroed, integral_saturated,
                    output ready);
endinterface

interface prc_cfg_if import prc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/prc_mul.sv =====
// ----------------------------------------------------------------------------
// prc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module prc_mul import prc_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/prc_div.sv =====
// ----------------------------------------------------------------------------
// prc_div
// Restoring divider, one quotient bit per cycle, for a known-bounded quotient.
// ----------------------------------------------------------------------------
module prc_div import prc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MAG_W-1:0]   i_dividend,
    input  logic [TIME_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [QUO_W-1:0]   o_quotient
);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MAG_W-1:0]   r_rem;
    logic [LIM_W-1:0]   r_dv;
    logic [QUO_W-1:0]   r_quo;
    logic               w_ge;

    assign w_ge = LIM_W'(r_rem) >= r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dv  <= LIM_W'({i_divisor, {(QUO_W-1){1'b0}}});
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dv[MAG_W-1:0];
            end
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_dv  <= r_dv >> 1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/pid_rate_controller.sv =====
// ----------------------------------------------------------------------------
// pid_rate_controller
// PID step with the derivative taken on the reference change.
//
// Step items enter on i_step, results leave on o_result, and gains are
// written on i_cfg, which is always ready. A clear item zeroes the integral
// in the cycle it is accepted and gives no result. A control step runs a
// sequencer around one registered multiplier: six products, one compare,
// then, unless the derivative is forced to zero, a restoring division of
// the derivative numerator by dt. The next item is accepted no earlier than
// the cycle after the result is loaded, so steps never overlap. The result
// sits in an output register; if the receiver stalls, a finished step waits
// for that register to empty before it is loaded. Reset clears the gains,
// the integral, the last reference and the last timestamp, with no clearing
// pass, and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module pid_rate_controller import prc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prc_step_if.sink     i_step,
    prc_result_if.source o_result,
    prc_cfg_if.sink      i_cfg
);

    t_state r_state, n_state;

    logic signed [GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic signed [ACC_W-1:0]   r_integral;
    logic signed [DATA_W-1:0]  r_last_ref;
    logic [TIME_W-1:0]         r_last_time;

    logic signed [ERR_W-1:0]   r_err, r_dref;
    logic [TIME_W-1:0]         r_dt;
    logic signed [P_W-1:0]     r_p;
    logic signed [ACC_W-1:0]   r_inc;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [D_W-1:0]     r_d;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_sat, r_dzero;

    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_out_dz, r_out_sat;

    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      w_step_acc, w_out_load, w_div_start, w_div_done;
    logic [QUO_W-1:0]          w_quo;
    logic                      w_inc_ovf;
    logic signed [ACC_W-1:0]   w_inc_cl;
    logic signed [ACC_W:0]     w_isum;
    logic                      w_isum_ovf;
    logic signed [ACC_W-1:0]   w_isum_cl;
    logic [MAG_W-1:0]          w_mag;
    logic                      w_dzero;
    logic signed [SHR_W-1:0]   w_shr;
    logic signed [DRIVE_W-1:0] w_drive;

    prc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    prc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_step_acc = i_step.valid && i_step.ready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_result.ready);

    assign w_inc_ovf = !((&w_prod[INC_W-1:ACC_W-1]) || !(|w_prod[INC_W-1:ACC_W-1]));
    assign w_inc_cl  = w_inc_ovf ? (w_prod[INC_W-1] ? ACC_MIN : ACC_MAX)
                                 : w_prod[ACC_W-1:0];

    assign w_isum     = (ACC_W+1)'(r_integral) + (ACC_W+1)'(r_inc);
    assign w_isum_ovf = w_isum[ACC_W] != w_isum[ACC_W-1];
    assign w_isum_cl  = w_isum_ovf ? (w_isum[ACC_W] ? ACC_MIN : ACC_MAX)
                                   : w_isum[ACC_W-1:0];

    assign w_mag   = r_num[NUM_W-1] ? MAG_W'(-r_num) : MAG_W'(r_num);
    assign w_dzero = (r_dt == '0) || (LIM_W'(w_mag) > w_prod[LIM_W-1:0]);

    assign w_shr   = r_sum[SUM_W-1:FRAC_W];
    assign w_drive = ((&w_shr[SHR_W-1:DRIVE_W-1]) || !(|w_shr[SHR_W-1:DRIVE_W-1]))
                     ? w_shr[DRIVE_W-1:0]
                     : (w_shr[SHR_W-1] ? DRIVE_MIN : DRIVE_MAX);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_step_acc && !i_step.clear_integral) begin
                    n_state = S_MUL_P;
                end
            end
            S_MUL_P:   n_state = S_MUL_KE;
            S_MUL_KE:  n_state = S_MUL_INC;
            S_MUL_INC: n_state = S_MUL_KD;
            S_MUL_KD:  n_state = S_MUL_NUM;
            S_MUL_NUM: n_state = S_MUL_LIM;
            S_MUL_LIM: n_state = S_CMP;
            S_CMP:     n_state = w_dzero ? S_SUM : S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:     n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_step.ready = 1'b0;
        w_div_start  = 1'b0;
        w_mul_a      = '0;
        w_mul_b      = '0;
        case (r_state)
            S_IDLE: i_step.ready = 1'b1;
            S_MUL_P: begin
                w_mul_a = MUL_W'(r_gain_p);
                w_mul_b = MUL_W'(r_err);
            end
            S_MUL_KE: begin
                w_mul_a = MUL_W'(r_gain_i);
                w_mul_b = MUL_W'(r_err);
            end
            S_MUL_INC: begin
                w_mul_a = w_prod[MUL_W-1:0];
                w_mul_b = MUL_W'(r_dt);
            end
            S_MUL_KD: begin
                w_mul_a = MUL_W'(r_gain_d);
                w_mul_b = MUL_W'(r_dref);
            end
            S_MUL_NUM: begin
                w_mul_a = w_prod[MUL_W-1:0];
                w_mul_b = MUL_W'(-MS_PER_S);
            end
            S_MUL_LIM: begin
                w_mul_a = MUL_W'(D_LIMIT_Q);
                w_mul_b = MUL_W'(r_dt);
            end
            S_CMP: w_div_start = !w_dzero;
            default: begin
                i_step.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_integral  <= '0;
            r_last_ref  <= '0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_GAIN_P: r_gain_p <= i_cfg.data;
                    CFG_GAIN_I: r_gain_i <= i_cfg.data;
                    CFG_GAIN_D: r_gain_d <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_step_acc) begin
                if (i_step.clear_integral) begin
                    r_integral <= '0;
                end else begin
                    r_last_ref  <= i_step.reference;
                    r_last_time <= i_step.now_ms;
                end
            end
            if (r_state == S_MUL_LIM) begin
                r_integral <= w_isum_cl;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_err  <= ERR_W'(i_step.measurement) - ERR_W'(i_step.reference);
                r_dref <= ERR_W'(i_step.reference) - ERR_W'(r_last_ref);
                r_dt   <= i_step.now_ms - r_last_time;
                r_sat  <= 1'b0;
            end
            S_MUL_KE: r_p <= w_prod[P_W-1:0];
            S_MUL_KD: begin
                r_inc <= w_inc_cl;
                r_sat <= w_inc_ovf;
            end
            S_MUL_LIM: begin
                r_num <= w_prod[NUM_W-1:0];
                r_sat <= r_sat | w_isum_ovf;
            end
            S_CMP: begin
                r_dzero <= w_dzero;
                r_d     <= '0;
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_d <= r_num[NUM_W-1] ? -D_W'(w_quo) : D_W'(w_quo);
                end
            end
            S_SUM: r_sum <= SUM_W'(r_p) + SUM_W'(r_integral) + SUM_W'(r_d);
            S_OUT: begin
                if (w_out_load) begin
                    r_drive   <= w_drive;
                    r_out_dz  <= r_dzero;
                    r_out_sat <= r_sat;
                end
            end
            default: ;
        endcase
    end

    assign i_cfg.ready                 = 1'b1;
    assign o_result.valid              = r_out_valid;
    assign o_result.drive              = r_drive;
    assign o_result.derivative_zeroed  = r_out_dz;
    assign o_result.integral_saturated = r_out_sat;

endmodule

// ===== test/pid_rate_controller_checker.sv =====
// ----------------------------------------------------------------------------
// pid_rate_controller_checker
// Watches the step, result and gain channels of the PID rate controller.
// It keeps its own copy of the gains and of the controller state, and from
// each accepted control step it works out the drive and both flags. Each
// accepted result is then compared, field by field, with the oldest
// outstanding prediction. It reports the number of failures and of results
// still outstanding.
// ----------------------------------------------------------------------------
module pid_rate_controller_checker import prc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    prc_step_if   i_step,
    prc_result_if i_result,
    prc_cfg_if    i_cfg,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      derivative_zeroed;
        logic                      integral_saturated;
    } t_drive_result;

    t_drive_result             drive_expected[$];
    logic signed [GAIN_W-1:0]  kp_q;
    logic signed [GAIN_W-1:0]  ki_q;
    logic signed [GAIN_W-1:0]  kd_q;
    longint                    integral_acc;
    logic signed [DATA_W-1:0]  prev_setpoint;
    logic [TIME_W-1:0]         prev_ms;

    function automatic longint clamp_acc(input longint v, inout bit hit);
        if (v > longint'(ACC_MAX)) begin
            hit = 1'b1;
            return longint'(ACC_MAX);
        end
        if (v < longint'(ACC_MIN)) begin
            hit = 1'b1;
            return longint'(ACC_MIN);
        end
        return v;
    endfunction

    function automatic void apply_control_step(input logic signed [DATA_W-1:0] meas,
                                               input logic signed [DATA_W-1:0] setpoint,
                                               input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] dt;
        longint unsigned   dt64;
        longint unsigned   mag;
        longint            err;
        longint            p_term;
        longint            inc;
        longint            num;
        longint            d_term;
        longint            total;
        bit                sat;
        bit                dzero;
        t_drive_result     want;

        dt     = now - prev_ms;
        dt64   = {32'd0, dt};
        err    = longint'(meas) - longint'(setpoint);
        p_term = longint'(kp_q) * err;
        sat    = 1'b0;
        dzero  = 1'b0;
        d_term = 0;

        inc          = clamp_acc(longint'(ki_q) * err * longint'(dt64), sat);
        integral_acc = clamp_acc(integral_acc + inc, sat);

        if (dt == '0) begin
            dzero = 1'b1;
        end else begin
            num = -longint'(kd_q) * (longint'(setpoint) - longint'(prev_setpoint))
                  * longint'(MS_PER_S);
            mag = (num < 0) ? longint'(-num) : num;
            if (mag > longint'(D_LIMIT_Q) * dt64) begin
                dzero = 1'b1;
            end else begin
                d_term = (num < 0) ? -longint'(mag / dt64) : longint'(mag / dt64);
            end
        end

        total = (p_term + integral_acc + d_term) >>> FRAC_W;
        if (total > longint'(DRIVE_MAX)) begin
            total = longint'(DRIVE_MAX);
        end else if (total < longint'(DRIVE_MIN)) begin
            total = longint'(DRIVE_MIN);
        end

        want.drive              = total[DRIVE_W-1:0];
        want.derivative_zeroed  = dzero;
        want.integral_saturated = sat;
        drive_expected.push_back(want);

        prev_ms       = now;
        prev_setpoint = setpoint;
    endfunction

    always @(posedge i_clk) begin
        t_drive_result seen;
        t_drive_result want;

        if (!i_rst_n) begin
            kp_q          = '0;
            ki_q          = '0;
            kd_q          = '0;
            integral_acc  = 0;
            prev_setpoint = '0;
            prev_ms       = '0;
            drive_expected.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                seen.drive              = i_result.drive;
                seen.derivative_zeroed  = i_result.derivative_zeroed;
                seen.integral_saturated = i_result.integral_saturated;
                if (drive_expected.size() == 0) begin
                    $error("unexpected result item: drive %0d", seen.drive);
                    o_fail_count++;
                end else begin
                    want = drive_expected.pop_front();
                    if (seen.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d", want.drive, seen.drive);
                        o_fail_count++;
                    end
                    if (seen.derivative_zeroed !== want.derivative_zeroed) begin
                        $error("derivative_zeroed: expected %0b, actual %0b",
                               want.derivative_zeroed, seen.derivative_zeroed);
                        o_fail_count++;
                    end
                    if (seen.integral_saturated !== want.integral_saturated) begin
                        $error("integral_saturated: expected %0b, actual %0b",
                               want.integral_saturated, seen.integral_saturated);
                        o_fail_count++;
                    end
                end
            end
            if (i_step.valid && i_step.ready) begin
                if (i_step.clear_integral) begin
                    integral_acc = 0;
                end else begin
                    apply_control_step(i_step.measurement, i_step.reference, i_step.now_ms);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_GAIN_P: kp_q = i_cfg.data;
                    CFG_GAIN_I: ki_q = i_cfg.data;
                    CFG_GAIN_D: kd_q = i_cfg.data;
                    default: ;
                endcase
            end
        end
        o_pending = drive_expected.size();
    end

endmodule

// ===== test/pid_rate_controller_test.sv =====
// ----------------------------------------------------------------------------
// pid_rate_controller_test
// Stimulus and verdict for the PID rate controller. A directed run covers
// the first step after reset, zero elapsed time, a derivative exactly at
// and over its limit, timestamp wrap, integral and drive saturation
// and clear items. Random segments follow, each with its own gains and one
// of four patterns of sender gaps and receiver stalls. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module pid_rate_controller_test;
    timeunit 1ns;
    timeprecision 1ps;
    import prc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 180;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    int                       src_idle_pct = 0;
    int                       sink_stall_pct = 0;
    int                       fail_count;
    int                       pending;
    int                       quiet_cycles = 0;
    logic [TIME_W-1:0]        stamp = '0;
    logic signed [DATA_W-1:0] last_setpoint = '0;

    prc_step_if   step_ch();
    prc_result_if result_ch();
    prc_cfg_if    cfg_ch();

    pid_rate_controller uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    pid_rate_controller_checker rate_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step_ch),
        .i_result     (result_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_HALF * 1ns) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (step_ch.valid && step_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("pid_rate_controller_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic clr, input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] setpoint,
                             input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            step_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        step_ch.valid          <= 1'b1;
        step_ch.clear_integral <= clr;
        step_ch.measurement    <= meas;
        step_ch.reference      <= setpoint;
        step_ch.now_ms         <= now;
        @(posedge i_clk);
        while (!step_ch.ready) @(posedge i_clk);
    endtask

    task automatic run_step(input logic signed [DATA_W-1:0] meas,
                            input logic signed [DATA_W-1:0] setpoint,
                            input logic [TIME_W-1:0] dt);
        stamp         = stamp + dt;
        last_setpoint = setpoint;
        send_item(1'b0, meas, setpoint, stamp);
    endtask

    task automatic clear_item();
        send_item(1'b1, DATA_W'($urandom), DATA_W'($urandom), $urandom);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        step_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd);
        settle();
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return '0;
            3, 4:    return GAIN_W'(int'($urandom_range(1023)) - 512);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic random_item();
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] setpoint;
        logic [TIME_W-1:0]        dt;

        if ($urandom_range(99) < 5) begin
            clear_item();
        end else begin
            if ($urandom_range(1) == 0) begin
                setpoint = last_setpoint + DATA_W'(int'($urandom_range(64)) - 32);
            end else begin
                setpoint = DATA_W'($urandom);
            end
            if ($urandom_range(1) == 0) begin
                meas = setpoint + DATA_W'(int'($urandom_range(512)) - 256);
            end else begin
                meas = DATA_W'($urandom);
            end
            case ($urandom_range(9))
                0:          dt = '0;
                1, 2, 3, 4: dt = $urandom_range(64, 1);
                5, 6:       dt = $urandom_range(200000, 1);
                7:          dt = 32'hFFFF_FFFF - $urandom_range(15);
                default:    dt = $urandom;
            endcase
            run_step(meas, setpoint, dt);
        end
    endtask

    initial begin
        i_rst_n                = 1'b0;
        step_ch.valid          = 1'b0;
        step_ch.clear_integral = 1'b0;
        step_ch.measurement    = '0;
        step_ch.reference      = '0;
        step_ch.now_ms         = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_GAIN_P;
        cfg_ch.data            = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unit P and D gains; the first step measures its elapsed time from zero.
        set_gains(16'd256, 16'd16, 16'd256);
        run_step(100, 10, 5);
        run_step(100, 10, 0);
        run_step(0, 20, 1);
        run_step(0, 21, 2);
        run_step(5, -3, 1000);
        clear_item();
        run_step(-32768, 32767, 32'hFFFF_FFFF - stamp);
        run_step(32767, -32768, 4);

        // Extreme gains drive the integral and the output into saturation.
        set_gains(16'h8000, 16'h7FFF, 16'h8000);
        write_reg(CFG_UNUSED, 16'h5A5A);
        run_step(32767, -32768, 32'hFFFF_FFFF);
        run_step(32767, -32768, 32'hFFFF_FFFF);
        run_step(-32768, 32767, 32'hFFFF_FFFF);
        run_step(-32768, 32767, 32'hFFFF_FFFF);
        clear_item();
        run_step(0, 0, 1);
        run_step(-32768, -32768, 0);

        set_gains(16'h7FFF, 16'h8000, 16'h7FFF);
        run_step(-32768, 32767, 1);
        run_step(32767, -32768, 32'h0200_0000);
        run_step(1, -1, 32'h8000_0000);
        run_step(0, 0, 0);
        run_step(-32768, 32767, 32'hFFFF_FFFF);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            set_gains(pick_gain(), pick_gain(), pick_gain());
            case (seg % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 82;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 82;
                end
                default: begin
                    src_idle_pct   = 15;
                    sink_stall_pct = 15;
                end
            endcase
            repeat (SEG_ITEMS) random_item();
        end

        settle();
        if (fail_count == 0) begin
            $display("pid_rate_controller_test passed");
        end else begin
            $display("pid_rate_controller_test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/prc_pkg.sv
rtl/prc_if.sv
rtl/prc_mul.sv
rtl/prc_div.sv
rtl/pid_rate_controller.sv
test/pid_rate_controller_checker.sv
test/pid_rate_controller_test.sv
